>>> sv/rff_pkg.sv
// Package for the receive frame filter: constants, verdict codes and CRC-8 step.
`default_nettype none
package rff_pkg;

  localparam int unsigned PORT_COUNT      = 16;
  localparam int unsigned MAX_FRAME_BYTES = 255;
  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned MAX_PAYLOAD     = MAX_FRAME_BYTES - 1 - HDR_BYTES;

  localparam logic [7:0] ADDR_NONE = 8'h00;
  localparam logic [7:0] ADDR_ALL  = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CNT_MAX   = 8'hFF;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE    = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT     = 3'd0,
    VERDICT_NOT_US     = 3'd1,
    VERDICT_BAD_PORT   = 3'd2,
    VERDICT_BAD_SIZE   = 3'd3,
    VERDICT_BAD_CRC    = 3'd4,
    VERDICT_NO_SERVICE = 3'd5,
    VERDICT_RUNT       = 3'd6,
    VERDICT_TOO_LONG   = 3'd7
  } verdict_e;

  // MSB-first CRC-8 update, no reflection, no final XOR
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/rx_frame_filter_crc8_top.sv
// Receive frame filter: header capture, CRC-8 check and one verdict per frame.
`default_nettype none
// Takes one frame byte per cycle while it does not stall. Non-final
// bytes never stall; a final byte stalls only while the previous verdict is still
// held in the output register and the sink stalls it. The verdict is registered and
// appears on the output in the cycle after the final byte is accepted, together with
// the captured header bytes and the frame length. The CRC-8 (poly 0x07, init 0)
// update is combinational XOR logic. Configuration writes are always ready and take
// effect on the next item.
module rx_frame_filter_crc8_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic                           last_byte_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [2:0]                     verdict_o,
  output      logic [7:0]                     dest_address_o,
  output      logic [7:0]                     src_address_o,
  output      logic [7:0]                     dest_port_o,
  output      logic [7:0]                     payload_size_o,
  output      logic [7:0]                     frame_length_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [rff_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rff_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rff_pkg::*;

  logic [7:0]  own_address_q;
  logic [15:0] port_enable_q;

  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] hdr_dest_q, hdr_dest_d;
  logic [7:0] hdr_src_q, hdr_src_d;
  logic [7:0] hdr_port_q, hdr_port_d;
  logic [7:0] hdr_size_q, hdr_size_d;
  logic       overlong_q, overlong_d;

  logic       out_valid_q;
  verdict_e   verdict_q, verdict_d;
  logic [7:0] dest_q, src_q, port_q, size_q, len_q;
  logic [7:0] len;

  logic in_accept, last_accept, addr_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = last_byte_i & out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign last_accept = in_accept & last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= ADDR_NONE;
      port_enable_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OWN_ADDRESS: own_address_q <= cfg_data_i[7:0];
        CFG_PORT_ENABLE: port_enable_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    overlong_d = overlong_q | (byte_count_q >= 8'(MAX_FRAME_BYTES));
    len        = (byte_count_q == CNT_MAX) ? CNT_MAX : byte_count_q + 8'd1;
    hdr_dest_d = (byte_count_q == 8'd0) ? rx_byte_i : hdr_dest_q;
    hdr_src_d  = (byte_count_q == 8'd1) ? rx_byte_i : hdr_src_q;
    hdr_port_d = (byte_count_q == 8'd2) ? rx_byte_i : hdr_port_q;
    hdr_size_d = (byte_count_q == 8'd3) ? rx_byte_i : hdr_size_q;
    crc_d        = crc8_next(crc_q, rx_byte_i);
    byte_count_d = len;
    addr_ok = (hdr_dest_d == ADDR_ALL) || (own_address_q == ADDR_NONE) ||
              (own_address_q == hdr_dest_d);
    priority if (len < 8'(HDR_BYTES + 1)) begin
      verdict_d = VERDICT_RUNT;
    end else if (overlong_d) begin
      verdict_d = VERDICT_TOO_LONG;
    end else if (!addr_ok) begin
      verdict_d = VERDICT_NOT_US;
    end else if (hdr_port_d >= 8'(PORT_COUNT)) begin
      verdict_d = VERDICT_BAD_PORT;
    end else if (hdr_size_d >= 8'(MAX_PAYLOAD)) begin
      verdict_d = VERDICT_BAD_SIZE;
    end else if (rx_byte_i != crc_q) begin
      verdict_d = VERDICT_BAD_CRC;
    end else if (!port_enable_q[hdr_port_d[3:0]]) begin
      verdict_d = VERDICT_NO_SERVICE;
    end else begin
      verdict_d = VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      crc_q        <= '0;
      hdr_dest_q   <= '0;
      hdr_src_q    <= '0;
      hdr_port_q   <= '0;
      hdr_size_q   <= '0;
      overlong_q   <= 1'b0;
    end else if (last_accept) begin
      byte_count_q <= '0;
      crc_q        <= '0;
      hdr_dest_q   <= '0;
      hdr_src_q    <= '0;
      hdr_port_q   <= '0;
      hdr_size_q   <= '0;
      overlong_q   <= 1'b0;
    end else if (in_accept) begin
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
      hdr_dest_q   <= hdr_dest_d;
      hdr_src_q    <= hdr_src_d;
      hdr_port_q   <= hdr_port_d;
      hdr_size_q   <= hdr_size_d;
      overlong_q   <= overlong_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_accept) begin
      verdict_q <= verdict_d;
      dest_q    <= hdr_dest_d;
      src_q     <= hdr_src_d;
      port_q    <= hdr_port_d;
      size_q    <= hdr_size_d;
      len_q     <= len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_q;
  assign dest_address_o = dest_q;
  assign src_address_o  = src_q;
  assign dest_port_o    = port_q;
  assign payload_size_o = size_q;
  assign frame_length_o = len_q;

endmodule
`default_nettype wire
